>>> rtl/sample_gap_interpolator_core_assert.svh
// Assertion macros for the gap interpolator core.
// Included by the top level; no other dependency.
`ifndef SAMPLE_GAP_INTERPOLATOR_CORE_ASSERT_SVH
`define SAMPLE_GAP_INTERPOLATOR_CORE_ASSERT_SVH
// implication checked every clock outside reset
`define SGI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%s failed", "label");
// next-cycle implication
`define SGI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%s failed", "label");
`endif

>>> rtl/sgi_pkg.sv
// Package for the gap interpolator: payload structs, FSM states, control structs.
// No dependencies.
package sgi_pkg;
    localparam int unsigned NCH = 6;

    typedef struct packed {
        logic               present;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_pitch;
        logic signed [31:0] in_roll;
        logic signed [31:0] in_yaw;
    } t_in_word;

    typedef struct packed {
        logic [7:0]         slot_index;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_pitch;
        logic signed [31:0] out_roll;
        logic signed [31:0] out_yaw;
        logic               interpolated;
        logic               gap_overflow;
        logic               last;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_NEXT_CH,
        ST_EMIT_FILL,
        ST_EMIT_SAMPLE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_item;   // capture input word, classify
        logic start_mul;   // form (cur-anchor)*i for current channel
        logic start_div;   // never raised; the divide begins with start_mul
        logic div_step;    // one quotient bit
        logic store_ch;    // write channel result, advance channel
        logic emit_fill;   // load output register with fill word
        logic emit_sample; // load output register with sample, commit anchor
        logic next_i;      // advance fill index
    } t_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic do_fill;     // item is present and has a fillable gap
        logic present;
        logic div_done;
        logic last_ch;
        logic last_i;
        logic out_busy;    // output register holds an untaken word
    } t_stat;
endpackage

>>> rtl/sample_gap_interpolator_core.sv
// Top level of the sample gap interpolator: controller plus datapath.
// Depends on sgi_pkg, sgi_ctrl, sgi_dpath and the assertion macro header.
//
// Each accepted word is one poll slot. A missing slot gives no result. A
// present slot with no fillable gap gives one result. A present slot after a
// gap of g-1 missing slots (g-1 <= MAX_GAP) gives g results. Each filled
// channel value goes through the single shared divider: a multiply state, a
// 38-step restoring divide at one quotient bit per cycle, and a store state.
// After all six channels, the filled word is loaded into the output register.
// The output register holds a finished word while the datapath keeps working.
// It only waits when the next word is ready before the last one was taken.
// Configuration (buffer_length) is written by i_cfg_we/i_cfg_wdata.
module sample_gap_interpolator_core #(
    parameter int unsigned MAX_GAP   = 32,
    parameter int unsigned MAX_SLOTS = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sgi_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sgi_pkg::t_out_word o_out_word
);
    import sgi_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;

    sgi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    sgi_dpath #(
        .MAX_GAP   (MAX_GAP),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_word   (i_in_word),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

`include "sample_gap_interpolator_core_assert.svh"

    // a filled word never claims to be the last or overflowed one
    `SGI_ASSERT_IMP(a_fill_flags, i_clk, i_rst_n,
        o_out_valid && o_out_word.interpolated,
        !o_out_word.last && !o_out_word.gap_overflow)
    // no new item is taken while results are still being produced
    `SGI_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n,
        o_out_valid && !o_out_word.last, !o_in_ready)
    // an accepted item blocks the input for the next cycle
    `SGI_ASSERT_NEXT(a_accept_blocks, i_clk, i_rst_n,
        i_in_valid && o_in_ready, !o_in_ready)
endmodule

>>> rtl/sgi_ctrl.sv
// Controller FSM for the gap interpolator.
// Depends on sgi_pkg.
module sgi_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sgi_pkg::t_stat i_stat,
    output sgi_pkg::t_ctrl o_ctrl
);
    import sgi_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (!i_stat.present) begin
                    n_state = ST_IDLE;
                end else if (i_stat.do_fill) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_EMIT_SAMPLE;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = ST_NEXT_CH;
                end
            end
            ST_NEXT_CH: begin
                if (i_stat.last_ch) begin
                    n_state = ST_EMIT_FILL;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_EMIT_FILL: begin
                if (!i_stat.out_busy) begin
                    n_state = i_stat.last_i ? ST_EMIT_SAMPLE : ST_MUL;
                end
            end
            ST_EMIT_SAMPLE: begin
                if (!i_stat.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_ctrl.load_item = i_in_valid;
            end
            ST_MUL: begin
                o_ctrl.start_mul = i_stat.do_fill;
            end
            ST_DIV: begin
                o_ctrl.div_step = 1'b1;
            end
            ST_NEXT_CH: begin
                o_ctrl.store_ch = 1'b1;
            end
            ST_EMIT_FILL: begin
                o_ctrl.emit_fill = !i_stat.out_busy;
                o_ctrl.next_i    = !i_stat.out_busy;
            end
            ST_EMIT_SAMPLE: begin
                o_ctrl.emit_sample = !i_stat.out_busy;
            end
            default: ;
        endcase
        o_ctrl.start_div = 1'b0;
    end
endmodule

>>> rtl/sgi_dpath.sv
// Datapath for the gap interpolator: anchor store, slot tracking,
// one shared multiplier, a restoring divider and the output register.
// Depends on sgi_pkg.
module sgi_dpath #(
    parameter int unsigned MAX_GAP   = 32,
    parameter int unsigned MAX_SLOTS = 255
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_wdata,
    input  sgi_pkg::t_in_word i_in_word,
    input  sgi_pkg::t_ctrl    i_ctrl,
    output sgi_pkg::t_stat    o_stat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sgi_pkg::t_out_word o_out_word
);
    import sgi_pkg::*;

    localparam int unsigned QW = 38; // |diff|*i < 2^33 * 2^6

    logic [7:0]         r_buf_len;
    logic               r_anchor_valid;
    logic [7:0]         r_anchor_slot;
    logic [7:0]         r_slot_pos;
    logic signed [31:0] r_anchor [NCH];
    logic signed [31:0] r_cur    [NCH];
    logic signed [31:0] r_fill   [NCH];
    logic               r_present;
    logic               r_do_fill;
    logic               r_ovf;
    logic [7:0]         r_pos;
    logic [7:0]         r_gap;      // g
    logic [7:0]         r_i;
    logic [2:0]         r_ch;
    logic [QW-1:0]      r_rem;      // dividend magnitude, shifted out
    logic [QW-1:0]      r_quo;
    logic [8:0]         r_part;     // partial remainder
    logic               r_neg;
    logic [5:0]         r_cnt;
    logic               r_div_busy;
    logic               r_out_valid;
    t_out_word          r_out;

    logic [7:0]  w_len;
    logic [7:0]  w_gap;
    logic        w_long;
    logic signed [32:0] w_diff;
    logic signed [QW:0] w_prod;
    logic [8:0]  w_trial;
    logic signed [31:0] w_res;

    always_comb begin
        w_len = (r_buf_len > 8'(MAX_SLOTS)) ? 8'(MAX_SLOTS) : r_buf_len;
        if (w_len == 8'd0) w_len = 8'd1;
        w_gap  = r_slot_pos - r_anchor_slot;
        w_long = ({1'b0, w_gap} - 9'd1) > 9'(MAX_GAP);
        w_diff = 33'(r_cur[r_ch]) - 33'(r_anchor[r_ch]);
        w_prod = (QW+1)'(w_diff * $signed({1'b0, r_i}));
        w_trial = {r_part[7:0], r_rem[QW-1]};
        w_res  = r_anchor[r_ch] + (r_neg ? -32'(r_quo) : 32'(r_quo));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_len      <= 8'd255;
            r_anchor_valid <= 1'b0;
            r_anchor_slot  <= '0;
            r_slot_pos     <= '0;
            r_out_valid    <= 1'b0;
            r_div_busy     <= 1'b0;
        end else begin
            if (i_cfg_we) r_buf_len <= i_cfg_wdata;
            if (o_out_valid && i_out_ready) r_out_valid <= 1'b0;
            if (i_ctrl.load_item) begin
                r_present <= i_in_word.present;
                r_pos     <= r_slot_pos;
                r_gap     <= w_gap;
                r_i       <= 8'd1;
                r_ch      <= '0;
                r_ovf     <= i_in_word.present && r_anchor_valid
                             && (r_slot_pos > r_anchor_slot + 8'd1) && w_long;
                r_do_fill <= i_in_word.present && r_anchor_valid
                             && (r_slot_pos > r_anchor_slot + 8'd1) && !w_long;
                r_cur[0] <= i_in_word.in_x;
                r_cur[1] <= i_in_word.in_y;
                r_cur[2] <= i_in_word.in_z;
                r_cur[3] <= i_in_word.in_pitch;
                r_cur[4] <= i_in_word.in_roll;
                r_cur[5] <= i_in_word.in_yaw;
                if ({1'b0, r_slot_pos} + 9'd1 >= {1'b0, w_len}) begin
                    r_slot_pos <= '0;
                    if (!i_in_word.present) r_anchor_valid <= 1'b0;
                end else begin
                    r_slot_pos <= r_slot_pos + 8'd1;
                end
            end
            if (i_ctrl.start_mul) begin
                r_neg      <= w_prod[QW];
                r_rem      <= w_prod[QW] ? QW'(-w_prod) : w_prod[QW-1:0];
                r_quo      <= '0;
                r_part     <= '0;
                r_cnt      <= '0;
                r_div_busy <= 1'b1;
            end
            if (i_ctrl.div_step && r_div_busy) begin
                r_rem <= {r_rem[QW-2:0], 1'b0};
                if (w_trial >= {1'b0, r_gap}) begin
                    r_part <= w_trial - {1'b0, r_gap};
                    r_quo  <= {r_quo[QW-2:0], 1'b1};
                end else begin
                    r_part <= w_trial;
                    r_quo  <= {r_quo[QW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(QW-1)) r_div_busy <= 1'b0;
            end
            if (i_ctrl.store_ch) begin
                r_fill[r_ch] <= w_res;
                r_ch <= (r_ch == 3'(NCH-1)) ? 3'd0 : r_ch + 3'd1;
            end
            if (i_ctrl.emit_fill) begin
                r_out_valid        <= 1'b1;
                r_out.slot_index   <= r_anchor_slot + r_i;
                r_out.out_x        <= r_fill[0];
                r_out.out_y        <= r_fill[1];
                r_out.out_z        <= r_fill[2];
                r_out.out_pitch    <= r_fill[3];
                r_out.out_roll     <= r_fill[4];
                r_out.out_yaw      <= r_fill[5];
                r_out.interpolated <= 1'b1;
                r_out.gap_overflow <= 1'b0;
                r_out.last         <= 1'b0;
            end
            if (i_ctrl.next_i) r_i <= r_i + 8'd1;
            if (i_ctrl.emit_sample) begin
                r_out_valid        <= 1'b1;
                r_out.slot_index   <= r_pos;
                r_out.out_x        <= r_cur[0];
                r_out.out_y        <= r_cur[1];
                r_out.out_z        <= r_cur[2];
                r_out.out_pitch    <= r_cur[3];
                r_out.out_roll     <= r_cur[4];
                r_out.out_yaw      <= r_cur[5];
                r_out.interpolated <= 1'b0;
                r_out.gap_overflow <= r_ovf;
                r_out.last         <= 1'b1;
                for (int c = 0; c < NCH; c++) r_anchor[c] <= r_cur[c];
                r_anchor_slot  <= r_pos;
                // frame wrapped on this slot: anchor dropped
                r_anchor_valid <= (r_slot_pos != 8'd0);
            end
        end
    end

    always_comb begin
        o_stat.do_fill  = r_do_fill;
        o_stat.present  = r_present;
        o_stat.div_done = r_div_busy && (r_cnt == 6'(QW-1));
        o_stat.last_ch  = (r_ch == 3'(NCH-1));
        o_stat.last_i   = (r_i + 8'd1 == r_gap);
        o_stat.out_busy = r_out_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
endmodule
